// ===== sv/bms_pkg.sv =====
// shared constants and types for the block mean / standard deviation unit
`timescale 1ns / 1ps
package bms_pkg;

   localparam int MAX_BLOCK_COLS_DEF = 64;
   localparam int SAMPLE_BITS_DEF    = 16;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLK_EDGE   = 2'd2;

   localparam logic [12:0] MAP_WIDTH_RST  = 13'd256;
   localparam logic [12:0] MAP_HEIGHT_RST = 13'd256;
   localparam logic [6:0]  BLK_EDGE_RST   = 7'd16;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACC,
      ST_E_RD,
      ST_E_LD,
      ST_E_DIV1,
      ST_E_MEAN,
      ST_E_DIV2,
      ST_E_SUB,
      ST_E_SQRT,
      ST_E_SAT,
      ST_E_OUT,
      ST_P_DIV,
      ST_P_FIN
   } state_type;

endpackage

// ===== sv/block_mean_stddev.sv =====
// Usage: raster height samples in on req_*, one block result per item out on rsp_*.
// Each accepted sample is added to its block column's sum, sum of squares and
// count, held in one synchronous memory: read at accept, written back the next
// cycle, and no new sample is taken until then. Samples of block columns past
// MAX_BLOCK_COLS are not stored. The sample that closes a band starts the
// result pass: per block one memory read, a shared bit-serial divider for the
// mean, again for the mean square, then a digit-serial square root; an empty
// block skips the divisions and the root. No input is taken during the pass.
// A result waits in the output registers while rsp_ready is low; the pass resumes
// when it is taken. The last result of the band clears the store's valid bits.
// Reset (synchronous) loads the register defaults, clears the positions and the
// store's valid bits at once. A block edge write holds off the next item while
// the divider redoes the column-to-block split of the current position.
// Configuration is written through csr_we / csr_index / csr_wdata at any edge.
`timescale 1ns / 1ps
module block_mean_stddev #(
   parameter int MAX_BLOCK_COLS = bms_pkg::MAX_BLOCK_COLS_DEF,
   parameter int SAMPLE_BITS    = bms_pkg::SAMPLE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [bms_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bms_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [15:0]               req_height_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [11:0]                      rsp_zone_x,
   output logic [11:0]                      rsp_zone_y,
   output logic signed [15:0]               rsp_mean_height,
   output logic [15:0]                      rsp_std_dev,
   output logic                             rsp_last_of_band,
   output logic                             rsp_last_of_map
);

   localparam int SUMW = SAMPLE_BITS + 12;
   localparam int SQW  = 2 * SAMPLE_BITS + 11;
   localparam int CW   = 13;
   localparam int DW   = SQW;
   localparam int AW   = (MAX_BLOCK_COLS > 1) ? $clog2(MAX_BLOCK_COLS) : 1;
   localparam int EW   = CW + SQW + SUMW;
   localparam int VARW = ((SQW > 32) ? SQW : 32) + 1;
   localparam int VW   = (VARW - 1) + ((VARW - 1) % 2);
   localparam int RW   = VW / 2;
   localparam int SCW  = $clog2(DW + 1);

   bms_pkg::state_type state_ff, state_in;

   logic [12:0] map_width_ff, map_height_ff;
   logic [6:0]  blk_edge_ff;
   logic [12:0] w_eff, h_eff;
   logic [6:0]  z_eff;

   logic [11:0] col_pos_ff, row_pos_ff, blk_ff;
   logic [5:0]  row_in_band_ff;
   logic [6:0]  off_ff;
   logic        dirty_ff;

   logic [MAX_BLOCK_COLS-1:0] vld_ff;
   logic [EW-1:0]             mem [MAX_BLOCK_COLS];
   logic [EW-1:0]             mem_q_ff;
   logic                      rd_vld_ff;
   logic [AW-1:0]             mem_ra, mem_wa;
   logic                      mem_we;
   logic [EW-1:0]             mem_wd;

   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic [23:0]                   sample_ext;
   logic signed [2*SAMPLE_BITS-1:0] prod;

   logic signed [SUMW-1:0] rd_sum, new_sum;
   logic [SQW-1:0]         rd_sq, new_sq;
   logic [CW-1:0]          rd_cnt, new_cnt;
   logic                   blk_in_range;

   logic row_end, map_end, band_end;

   logic [SQW-1:0]  ld_sq_ff;
   logic [AW-1:0]   k_ff;
   logic [11:0]     zx_ff, zy_ff;
   logic            map_end_ff;
   logic            last_blk;

   logic [DW-1:0]   num_ff;
   logic [CW-1:0]   den_ff;
   logic [CW-1:0]   rem_ff;
   logic [SCW-1:0]  cnt_ff;
   logic            neg_ff;
   logic [CW:0]     div_sh, div_sub;
   logic            div_ge;
   logic            div_done, sqrt_done;

   logic signed [15:0] mean_ff;
   logic signed [31:0] mean_sq;
   logic [31:0]        msq_ff;
   logic [15:0]        sd_ff;
   logic [VARW-1:0]    q_ext, m_ext, var_diff;

   logic [VW-1:0]   rad_ff;
   logic [RW+1:0]   srem_ff;
   logic [RW-1:0]   root_ff;
   logic [RW+1:0]   s_r4, s_trial;
   logic            s_ge;
   logic [31:0]     root32;

   // effective configuration
   always_comb begin
      w_eff = (map_width_ff == 13'd0) ? 13'd1 :
              (map_width_ff > 13'd4096) ? 13'd4096 : map_width_ff;
      h_eff = (map_height_ff == 13'd0) ? 13'd1 :
              (map_height_ff > 13'd4096) ? 13'd4096 : map_height_ff;
      z_eff = (blk_edge_ff == 7'd0) ? 7'd1 :
              (blk_edge_ff > 7'd64) ? 7'd64 : blk_edge_ff;
   end

   assign sample_ext = {8'd0, req_height_sample};
   assign prod       = sample_ff * sample_ff;
   assign mean_sq    = mean_ff * mean_ff;

   always_comb begin
      rd_sum = rd_vld_ff ? mem_q_ff[SUMW-1:0] : '0;
      rd_sq  = rd_vld_ff ? mem_q_ff[SUMW +: SQW] : '0;
      rd_cnt = rd_vld_ff ? mem_q_ff[SUMW+SQW +: CW] : '0;
      new_sum = rd_sum + SUMW'(sample_ff);
      new_sq  = rd_sq + SQW'($unsigned(prod));
      new_cnt = rd_cnt + CW'(1);
   end

   assign blk_in_range = blk_ff < 12'(MAX_BLOCK_COLS);
   assign row_end  = ({1'b0, col_pos_ff} + 13'd1) >= w_eff;
   assign map_end  = ({1'b0, row_pos_ff} + 13'd1) >= h_eff;
   assign band_end = map_end || (({1'b0, row_in_band_ff} + 7'd1) >= z_eff);
   assign last_blk = (({2'b0, zx_ff} + {7'd0, z_eff}) >= {1'b0, w_eff}) ||
                     (k_ff == AW'(MAX_BLOCK_COLS - 1));

   // shared restoring divider step
   always_comb begin
      div_sh  = {rem_ff, num_ff[DW-1]};
      div_ge  = div_sh >= {1'b0, den_ff};
      div_sub = div_sh - {1'b0, den_ff};
   end
   assign div_done  = cnt_ff == SCW'(DW - 1);
   assign sqrt_done = cnt_ff == SCW'(RW - 1);

   // square root digit step
   always_comb begin
      s_r4    = {srem_ff[RW-1:0], rad_ff[VW-1:VW-2]};
      s_trial = {root_ff, 2'b01};
      s_ge    = s_r4 >= s_trial;
      q_ext    = VARW'(num_ff);
      m_ext    = VARW'(msq_ff);
      var_diff = q_ext - m_ext;
      root32   = 32'(root_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bms_pkg::ST_IDLE: begin
            if (dirty_ff) state_in = bms_pkg::ST_P_DIV;
            else if (req_valid) state_in = bms_pkg::ST_ACC;
         end
         bms_pkg::ST_ACC: begin
            if (row_end && band_end) state_in = bms_pkg::ST_E_RD;
            else state_in = bms_pkg::ST_IDLE;
         end
         bms_pkg::ST_E_RD: state_in = bms_pkg::ST_E_LD;
         bms_pkg::ST_E_LD: begin
            if (rd_cnt == '0) state_in = bms_pkg::ST_E_OUT;
            else state_in = bms_pkg::ST_E_DIV1;
         end
         bms_pkg::ST_E_DIV1: if (div_done) state_in = bms_pkg::ST_E_MEAN;
         bms_pkg::ST_E_MEAN: state_in = bms_pkg::ST_E_DIV2;
         bms_pkg::ST_E_DIV2: if (div_done) state_in = bms_pkg::ST_E_SUB;
         bms_pkg::ST_E_SUB:  state_in = bms_pkg::ST_E_SQRT;
         bms_pkg::ST_E_SQRT: if (sqrt_done) state_in = bms_pkg::ST_E_SAT;
         bms_pkg::ST_E_SAT:  state_in = bms_pkg::ST_E_OUT;
         bms_pkg::ST_E_OUT: begin
            if (rsp_ready) state_in = last_blk ? bms_pkg::ST_IDLE : bms_pkg::ST_E_RD;
         end
         bms_pkg::ST_P_DIV: if (div_done) state_in = bms_pkg::ST_P_FIN;
         bms_pkg::ST_P_FIN: state_in = bms_pkg::ST_IDLE;
         default: state_in = bms_pkg::ST_IDLE;
      endcase
   end

   // outputs and memory control
   always_comb begin
      req_ready = (state_ff == bms_pkg::ST_IDLE) && !dirty_ff;
      rsp_valid = state_ff == bms_pkg::ST_E_OUT;
      mem_ra    = (state_ff == bms_pkg::ST_IDLE) ? blk_ff[AW-1:0] : k_ff;
      mem_wa    = blk_ff[AW-1:0];
      mem_we    = (state_ff == bms_pkg::ST_ACC) && blk_in_range;
      mem_wd    = {new_cnt, new_sq, new_sum};
   end

   assign rsp_zone_x       = zx_ff;
   assign rsp_zone_y       = zy_ff;
   assign rsp_mean_height  = mean_ff;
   assign rsp_std_dev      = sd_ff;
   assign rsp_last_of_band = last_blk;
   assign rsp_last_of_map  = last_blk && map_end_ff;

   // accumulator store
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      mem_q_ff <= mem[mem_ra];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= bms_pkg::ST_IDLE;
         map_width_ff   <= bms_pkg::MAP_WIDTH_RST;
         map_height_ff  <= bms_pkg::MAP_HEIGHT_RST;
         blk_edge_ff    <= bms_pkg::BLK_EDGE_RST;
         col_pos_ff     <= '0;
         row_pos_ff     <= '0;
         row_in_band_ff <= '0;
         blk_ff         <= '0;
         off_ff         <= '0;
         dirty_ff       <= 1'b0;
         vld_ff         <= '0;
         rd_vld_ff      <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= vld_ff[mem_ra];
         if (csr_we && csr_index == bms_pkg::CSR_BLK_EDGE) dirty_ff <= 1'b1;
         else if (state_ff == bms_pkg::ST_IDLE && dirty_ff) dirty_ff <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               bms_pkg::CSR_MAP_WIDTH:  map_width_ff  <= csr_wdata;
               bms_pkg::CSR_MAP_HEIGHT: map_height_ff <= csr_wdata;
               bms_pkg::CSR_BLK_EDGE:   blk_edge_ff   <= csr_wdata[6:0];
               default: ;
            endcase
         end
         if (mem_we) vld_ff[mem_wa] <= 1'b1;
         if (state_ff == bms_pkg::ST_ACC) begin
            if (!row_end) begin
               col_pos_ff <= col_pos_ff + 12'd1;
               if ((off_ff + 7'd1) == z_eff) begin
                  off_ff <= '0;
                  blk_ff <= blk_ff + 12'd1;
               end else begin
                  off_ff <= off_ff + 7'd1;
               end
            end else begin
               col_pos_ff <= '0;
               blk_ff     <= '0;
               off_ff     <= '0;
               if (!band_end) begin
                  row_in_band_ff <= row_in_band_ff + 6'd1;
                  row_pos_ff     <= row_pos_ff + 12'd1;
               end else begin
                  row_in_band_ff <= '0;
                  row_pos_ff     <= map_end ? 12'd0 : row_pos_ff + 12'd1;
               end
            end
         end
         if (state_ff == bms_pkg::ST_P_FIN) begin
            blk_ff <= num_ff[11:0];
            off_ff <= rem_ff[6:0];
         end
         if (state_ff == bms_pkg::ST_E_OUT && rsp_ready && last_blk) vld_ff <= '0;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      msq_ff <= $unsigned(mean_sq);
      case (state_ff)
         bms_pkg::ST_IDLE: begin
            sample_ff <= sample_ext[SAMPLE_BITS-1:0];
            num_ff    <= DW'(col_pos_ff);
            den_ff    <= CW'(z_eff);
            rem_ff    <= '0;
            cnt_ff    <= '0;
         end
         bms_pkg::ST_ACC: begin
            zy_ff      <= row_pos_ff - {6'd0, row_in_band_ff};
            map_end_ff <= map_end;
            k_ff       <= '0;
            zx_ff      <= '0;
         end
         bms_pkg::ST_E_LD: begin
            neg_ff   <= rd_sum[SUMW-1];
            num_ff   <= DW'(rd_sum[SUMW-1] ? $unsigned(-rd_sum) : $unsigned(rd_sum));
            den_ff   <= rd_cnt;
            ld_sq_ff <= rd_sq;
            rem_ff   <= '0;
            cnt_ff   <= '0;
            mean_ff  <= '0;
            sd_ff    <= '0;
         end
         bms_pkg::ST_P_DIV, bms_pkg::ST_E_DIV1, bms_pkg::ST_E_DIV2: begin
            num_ff <= {num_ff[DW-2:0], div_ge};
            rem_ff <= div_ge ? div_sub[CW-1:0] : div_sh[CW-1:0];
            cnt_ff <= cnt_ff + SCW'(1);
         end
         bms_pkg::ST_E_MEAN: begin
            if (!neg_ff) begin
               mean_ff <= (num_ff > DW'(32767)) ? 16'sh7FFF : $signed(num_ff[15:0]);
            end else begin
               mean_ff <= (num_ff > DW'(32768)) ? 16'sh8000 : -$signed(num_ff[15:0]);
            end
            num_ff <= ld_sq_ff;
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         bms_pkg::ST_E_SUB: begin
            rad_ff  <= (q_ext < m_ext) ? '0 : VW'(var_diff[VARW-2:0]);
            srem_ff <= '0;
            root_ff <= '0;
            cnt_ff  <= '0;
         end
         bms_pkg::ST_E_SQRT: begin
            rad_ff  <= {rad_ff[VW-3:0], 2'b00};
            srem_ff <= s_ge ? (s_r4 - s_trial) : s_r4;
            root_ff <= {root_ff[RW-2:0], s_ge};
            cnt_ff  <= cnt_ff + SCW'(1);
         end
         bms_pkg::ST_E_SAT: begin
            sd_ff <= (root32 > 32'd65535) ? 16'hFFFF : root32[15:0];
         end
         bms_pkg::ST_E_OUT: begin
            if (rsp_ready) begin
               k_ff  <= k_ff + AW'(1);
               zx_ff <= zx_ff + {5'd0, z_eff};
            end
         end
         default: ;
      endcase
   end

endmodule

// ===== sv/bms_checker.sv =====
// port-level checks for the block mean / standard deviation unit
`timescale 1ns / 1ps
module bms_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [11:0]        rsp_zone_x,
   input logic signed [15:0] rsp_mean_height,
   input logic               rsp_last_of_band,
   input logic               rsp_last_of_map
);

   // stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_zone_x) &&
      $stable(rsp_mean_height))
      else $error("stalled result item changed");

   // no input taken while results are pending
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input ready during result pass");

   a_map_band: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_last_of_map || rsp_last_of_band))
      else $error("end of map without end of band");

   // band pass continues after a non-final item
   a_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_band |=> !req_ready)
      else $error("band pass stopped early");

endmodule

bind block_mean_stddev bms_checker u_bms_checker (.*);
